[hw/rtl/gibs_pkg.sv]
// ----------------------------------------------------------------------------
// gibs_pkg: shared types and constants of the glyph index engine
// Table geometry, field widths, entry layout, and the codes used on the ports.
// ----------------------------------------------------------------------------
package gibs_pkg;

  // Table geometry.
  localparam int TABLE_DEPTH = 8192;
  localparam int ADDR_W      = $clog2(TABLE_DEPTH);
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

  // Fixed field widths.
  localparam int CP_W     = 21;
  localparam int OFF_W    = 32;
  localparam int SIZE_W   = 16;
  localparam int IDX_W    = 13;
  localparam int COUNT_W  = 14;
  localparam int CFG_W    = 16;
  localparam int CFG_IX_W = 1;

  // Action codes.
  localparam logic ACT_LOAD   = 1'b0;
  localparam logic ACT_LOOKUP = 1'b1;

  // Register indexes.
  localparam logic [CFG_IX_W-1:0] REG_ENTRY_COUNT = 1'b0;
  localparam logic [CFG_IX_W-1:0] REG_FONT_SIZE   = 1'b1;

  // Status codes.
  localparam logic STATUS_FOUND     = 1'b0;
  localparam logic STATUS_NOT_FOUND = 1'b1;

  // The space character has no bitmap.
  localparam logic [CP_W-1:0] SPACE_CODE = 21'h20;

  // One table entry.
  typedef struct packed {
    logic [CP_W-1:0]  code;
    logic [OFF_W-1:0] offset;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  // Read request from the search sequencer to the table.
  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
  } rd_req_t;

endpackage

[hw/rtl/glyph_index_binary_search.sv]
// ----------------------------------------------------------------------------
// glyph_index_binary_search: glyph index engine
// Load beats write one sorted table entry and produce no result.
// Lookup beats binary-search the first entry_count entries of the table.
// A lookup that hits on probe P strobes done after that probe; a miss strobes
// it after P probes and a final check that finds the range empty.
// P is at most 14 for the full 8192-entry table. Each probe reads the table
// memory synchronously in the probe state and compares the returned entry in
// the compare state.
// One lookup at a time; the receiver cannot stall. Reset clears the config
// registers and the sequencer; table contents stay undefined until loaded.
// ----------------------------------------------------------------------------
module glyph_index_binary_search import gibs_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  logic                action,
  input  logic [IDX_W-1:0]    entry_index,
  input  logic [CP_W-1:0]     code_point,
  input  logic [OFF_W-1:0]    record_offset,
  input  logic [SIZE_W-1:0]   requested_size,
  input  logic                cfg_we,
  input  logic [CFG_IX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]    cfg_data,
  output logic                done,
  output logic                status,
  output logic [OFF_W-1:0]    found_offset,
  output logic                has_bitmap
);

  logic [COUNT_W-1:0] entry_count;
  logic [SIZE_W-1:0]  table_font_size;
  logic               accept;
  logic               load_we;
  logic               lookup;
  rd_req_t            rd_req;
  entry_t             wr_entry;
  entry_t             rd_entry;
  logic [ENTRY_W-1:0] rd_bits;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      entry_count     <= '0;
      table_font_size <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_ENTRY_COUNT: entry_count     <= cfg_data[COUNT_W-1:0];
        REG_FONT_SIZE:   table_font_size <= cfg_data[SIZE_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Beat decode; loads past the table depth are dropped.
  assign accept  = start && !busy;
  assign load_we = accept && (action == ACT_LOAD) && (32'(entry_index) < TABLE_DEPTH);
  assign lookup  = accept && (action == ACT_LOOKUP);

  assign wr_entry.code   = code_point;
  assign wr_entry.offset = record_offset;
  assign rd_entry        = entry_t'(rd_bits);

  gibs_table_ram #(
    .DATA_W (ENTRY_W),
    .ADDR_W (ADDR_W)
  ) u_ram (
    .clk     (clk),
    .wr_en   (load_we),
    .wr_addr (ADDR_W'(entry_index)),
    .wr_data (wr_entry),
    .rd_en   (rd_req.en),
    .rd_addr (rd_req.addr),
    .rd_data (rd_bits)
  );

  gibs_search u_search (
    .clk             (clk),
    .rst             (rst),
    .lookup          (lookup),
    .key_in          (code_point),
    .requested_size  (requested_size),
    .table_font_size (table_font_size),
    .entry_count     (entry_count),
    .rd_req          (rd_req),
    .rd_data         (rd_entry),
    .busy            (busy),
    .done            (done),
    .status          (status),
    .found_offset    (found_offset),
    .has_bitmap      (has_bitmap)
  );

endmodule

[hw/rtl/gibs_table_ram.sv]
// ----------------------------------------------------------------------------
// gibs_table_ram: glyph table storage
// Simple dual-port synchronous RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module gibs_table_ram #(
  parameter int DATA_W = 53,
  parameter int ADDR_W = 13
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [DATA_W-1:0] wr_data,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [DATA_W-1:0] rd_data
);

  logic [DATA_W-1:0] mem [2**ADDR_W];

  // Write port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

[hw/rtl/gibs_search.sv]
// ----------------------------------------------------------------------------
// gibs_search: binary search sequencer
// Walks the sorted table one probe at a time and registers the lookup result.
// ----------------------------------------------------------------------------
module gibs_search import gibs_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               lookup,
  input  logic [CP_W-1:0]    key_in,
  input  logic [SIZE_W-1:0]  requested_size,
  input  logic [SIZE_W-1:0]  table_font_size,
  input  logic [COUNT_W-1:0] entry_count,
  output rd_req_t            rd_req,
  input  entry_t             rd_data,
  output logic               busy,
  output logic               done,
  output logic               status,
  output logic [OFF_W-1:0]   found_offset,
  output logic               has_bitmap
);

  typedef enum logic [2:0] {
    S_IDLE  = 3'b001,
    S_PROBE = 3'b010,
    S_CMP   = 3'b100
  } state_t;

  state_t            state, state_next;
  logic [CNT_W-1:0]  lo, lo_next;
  logic [CNT_W-1:0]  hx, hx_next;
  logic [ADDR_W-1:0] mid;
  logic [CP_W-1:0]   key;
  logic              done_next;
  logic              status_next;
  logic [OFF_W-1:0]  found_offset_next;
  logic              has_bitmap_next;

  logic [CNT_W-1:0]  count_clamped;
  logic [CNT_W:0]    mid_sum;
  logic [ADDR_W-1:0] mid_calc;
  logic              range_open;
  logic              size_ok;

  // A count above the depth searches the whole table.
  assign count_clamped = (entry_count > COUNT_W'(TABLE_DEPTH)) ? CNT_W'(TABLE_DEPTH)
                                                               : CNT_W'(entry_count);
  assign size_ok = (requested_size == table_font_size);

  // The open range is [lo, hx); the probe sits at the lower middle.
  assign range_open = (lo < hx);
  assign mid_sum    = {1'b0, lo} + {1'b0, hx} - (CNT_W + 1)'(1);
  assign mid_calc   = mid_sum[ADDR_W:1];

  assign rd_req.en   = (state == S_PROBE) && range_open;
  assign rd_req.addr = mid_calc;
  assign busy        = (state != S_IDLE);

  // Sequencer next state and result.
  always_comb begin
    state_next        = state;
    lo_next           = lo;
    hx_next           = hx;
    done_next         = 1'b0;
    status_next       = status;
    found_offset_next = found_offset;
    has_bitmap_next   = has_bitmap;
    case (state)
      S_IDLE: begin
        if (lookup) begin
          lo_next    = '0;
          // A size mismatch searches an empty range and so is not found.
          hx_next    = size_ok ? count_clamped : '0;
          state_next = S_PROBE;
        end
      end
      S_PROBE: begin
        if (range_open) begin
          state_next = S_CMP;
        end else begin
          done_next         = 1'b1;
          status_next       = STATUS_NOT_FOUND;
          found_offset_next = '0;
          has_bitmap_next   = 1'b0;
          state_next        = S_IDLE;
        end
      end
      S_CMP: begin
        if (rd_data.code == key) begin
          done_next         = 1'b1;
          status_next       = STATUS_FOUND;
          found_offset_next = rd_data.offset;
          has_bitmap_next   = (key != SPACE_CODE);
          state_next        = S_IDLE;
        end else if (rd_data.code < key) begin
          lo_next    = CNT_W'({1'b0, mid} + (ADDR_W + 1)'(1));
          state_next = S_PROBE;
        end else begin
          hx_next    = CNT_W'(mid);
          state_next = S_PROBE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= done_next;
    end
  end

  // Search bounds, key and result payload.
  always_ff @(posedge clk) begin
    lo           <= lo_next;
    hx           <= hx_next;
    status       <= status_next;
    found_offset <= found_offset_next;
    has_bitmap   <= has_bitmap_next;
    if (rd_req.en) begin
      mid <= mid_calc;
    end
    if (lookup && (state == S_IDLE)) begin
      key <= key_in;
    end
  end

endmodule

[hw/rtl/gibs_checker.sv]
// ----------------------------------------------------------------------------
// gibs_checker: port-level checks of the glyph index engine
// Watches the top level ports and flags result or sequencing slips.
// ----------------------------------------------------------------------------
module gibs_checker import gibs_pkg::*; (
  input logic                clk,
  input logic                rst,
  input logic                start,
  input logic                busy,
  input logic                action,
  input logic                done,
  input logic                status,
  input logic [OFF_W-1:0]    found_offset,
  input logic                has_bitmap
);

  // A taken lookup keeps the engine busy for the search.
  assert property (@(posedge clk) disable iff (rst)
    (start && !busy && action == ACT_LOOKUP) |=> busy)
    else $error("lookup beat did not raise busy");

  // A load beat completes at once and produces no result.
  assert property (@(posedge clk) disable iff (rst)
    (start && !busy && action == ACT_LOAD) |=> (!busy && !done))
    else $error("load beat started a search or produced a result");

  // Results never come back to back.
  assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("result strobe held for more than one cycle");

  // A miss carries a zero offset and no bitmap.
  assert property (@(posedge clk) disable iff (rst)
    (done && status == STATUS_NOT_FOUND) |-> (found_offset == '0 && !has_bitmap))
    else $error("not-found result carries offset or bitmap flag");

  // A bitmap is only reported for a hit.
  assert property (@(posedge clk) disable iff (rst)
    (done && has_bitmap) |-> (status == STATUS_FOUND))
    else $error("bitmap flag set on a miss");

endmodule

bind glyph_index_binary_search gibs_checker u_gibs_checker (.*);

[bench/glyph_index_binary_search_test.sv]
// ----------------------------------------------------------------------------
// glyph_index_binary_search_test: self-checking bench for the glyph index engine
// The bench loads the low eighth of the table with ascending code points,
// plus the entries that a full-table search probes on its way down. It then
// runs directed lookups and random phases of loads and lookups under changing
// entry counts and font sizes. A shadow copy of the table and registers
// predicts each lookup answer, and every done beat is checked in order.
// ----------------------------------------------------------------------------
module glyph_index_binary_search_test;
  import gibs_pkg::*;

  localparam int CP_MAX        = 1114111;
  localparam int FILL_COUNT    = TABLE_DEPTH / 8;
  localparam int CODE_STRIDE   = (CP_MAX + 1) / FILL_COUNT;
  localparam int ITEM_COUNT    = 1950;
  localparam int CALM_TAIL     = 250;
  localparam int SETTLE_CYCLES = 32;
  localparam int DRAIN_CYCLES  = 40;
  localparam int STALL_LIMIT   = 1000;

  typedef enum logic [1:0] {REQ_BEAT, REQ_CFG, REQ_PAUSE} req_kind_t;

  typedef struct packed {
    req_kind_t           kind;
    logic                act;
    logic [IDX_W-1:0]    idx;
    logic [CP_W-1:0]     code;
    logic [OFF_W-1:0]    offset;
    logic [SIZE_W-1:0]   req_size;
    logic [CFG_IX_W-1:0] reg_ix;
    logic [CFG_W-1:0]    reg_val;
  } glyph_req_t;

  typedef struct packed {
    logic             status;
    logic [OFF_W-1:0] offset;
    logic             bitmap;
  } glyph_ans_t;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                start = 1'b0;
  logic                busy;
  logic                action = ACT_LOAD;
  logic [IDX_W-1:0]    entry_index = '0;
  logic [CP_W-1:0]     code_point = '0;
  logic [OFF_W-1:0]    record_offset = '0;
  logic [SIZE_W-1:0]   requested_size = '0;
  logic                cfg_we = 1'b0;
  logic [CFG_IX_W-1:0] cfg_index = REG_ENTRY_COUNT;
  logic [CFG_W-1:0]    cfg_data = '0;
  logic                done;
  logic                status;
  logic [OFF_W-1:0]    found_offset;
  logic                has_bitmap;

  glyph_index_binary_search DUT (
    .clk            (clk),
    .rst            (rst),
    .start          (start),
    .busy           (busy),
    .action         (action),
    .entry_index    (entry_index),
    .code_point     (code_point),
    .record_offset  (record_offset),
    .requested_size (requested_size),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .done           (done),
    .status         (status),
    .found_offset   (found_offset),
    .has_bitmap     (has_bitmap)
  );

  // Stimulus backlog and the answers still owed by the block.
  glyph_req_t req_backlog[$];
  glyph_ans_t owed_answers[$];
  int         beats_total = 0;
  int         beats_taken = 0;
  int         faults = 0;

  // Generator view of the table, used only to aim lookups and loads.
  int                plan_code[TABLE_DEPTH];
  int                gen_count = 0;
  logic [SIZE_W-1:0] gen_font = '0;

  // Shadow of the block state used for prediction.
  logic [CP_W-1:0]    shadow_code[TABLE_DEPTH];
  logic [OFF_W-1:0]   shadow_offset[TABLE_DEPTH];
  logic [COUNT_W-1:0] shadow_count;
  logic [SIZE_W-1:0]  shadow_font;

  // Driver bookkeeping.
  glyph_req_t cur_req;
  int         gap_left;
  int         quiet_cycles;
  int         idle_cycles = 0;

  initial begin
    forever #10 clk = ~clk;
  end

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
  end

  // Binary search over the shadow table, same halving order as the block.
  function automatic glyph_ans_t answer_lookup(logic [CP_W-1:0] key,
                                               logic [SIZE_W-1:0] want_size);
    glyph_ans_t a;
    int         lo;
    int         hi;
    int         mid;
    logic       hit;
    a.status = STATUS_NOT_FOUND;
    a.offset = '0;
    a.bitmap = 1'b0;
    hit = 1'b0;
    mid = 0;
    lo = 0;
    hi = ((shadow_count > TABLE_DEPTH) ? TABLE_DEPTH : int'(shadow_count)) - 1;
    while (!hit && lo <= hi) begin
      mid = lo + ((hi - lo) >> 1);
      if (shadow_code[mid] == key) hit = 1'b1;
      else if (shadow_code[mid] < key) lo = mid + 1;
      else hi = mid - 1;
    end
    if (hit && want_size == shadow_font) begin
      a.status = STATUS_FOUND;
      a.offset = shadow_offset[mid];
      a.bitmap = (key != SPACE_CODE);
    end
    return a;
  endfunction

  // Apply one accepted beat to the shadow state.
  task automatic shadow_beat(glyph_req_t r);
    if (r.act == ACT_LOAD) begin
      shadow_code[r.idx] = r.code;
      shadow_offset[r.idx] = r.offset;
    end else begin
      owed_answers.push_back(answer_lookup(r.code, r.req_size));
    end
  endtask

  task automatic queue_load(int idx, int code, logic [OFF_W-1:0] offset);
    glyph_req_t r;
    r.kind = REQ_BEAT;
    r.act = ACT_LOAD;
    r.idx = IDX_W'(idx);
    r.code = CP_W'(code);
    r.offset = offset;
    r.req_size = SIZE_W'($urandom);
    r.reg_ix = REG_ENTRY_COUNT;
    r.reg_val = '0;
    req_backlog.push_back(r);
    plan_code[idx] = code;
    beats_total++;
  endtask

  task automatic queue_lookup(int code, logic [SIZE_W-1:0] want_size);
    glyph_req_t r;
    r.kind = REQ_BEAT;
    r.act = ACT_LOOKUP;
    r.idx = IDX_W'($urandom);
    r.code = CP_W'(code);
    r.offset = $urandom;
    r.req_size = want_size;
    r.reg_ix = REG_ENTRY_COUNT;
    r.reg_val = '0;
    req_backlog.push_back(r);
    beats_total++;
  endtask

  task automatic queue_config(logic [CFG_IX_W-1:0] ix, int val);
    glyph_req_t r;
    r = '0;
    r.kind = REQ_CFG;
    r.reg_ix = ix;
    r.reg_val = CFG_W'(val);
    req_backlog.push_back(r);
    if (ix == REG_ENTRY_COUNT) begin
      gen_count = val & 16'h3FFF;
      if (gen_count > TABLE_DEPTH) gen_count = TABLE_DEPTH;
    end else begin
      gen_font = SIZE_W'(val);
    end
  endtask

  task automatic queue_pause();
    glyph_req_t r;
    r = '0;
    r.kind = REQ_PAUSE;
    req_backlog.push_back(r);
  endtask

  // Stimulus generation, then the end of the run.
  initial begin
    int roll;
    int code;
    int j;
    int lo_b;
    int hi_b;
    int span;
    logic [SIZE_W-1:0] sz;

    // An empty table answers not found even before anything is loaded.
    queue_lookup($urandom_range(0, CP_MAX), 16'h0);

    // Fill the low part of the table with ascending code points; its last
    // entry holds the top code so no search ever walks above it.
    for (int i = 0; i < FILL_COUNT; i++) begin
      if (i == 0) queue_load(i, 0, 32'hFFFF_FFFF);
      else if (i == 1) queue_load(i, SPACE_CODE, 32'h0);
      else if (i == FILL_COUNT - 1) queue_load(i, CP_MAX, $urandom);
      else queue_load(i, i * CODE_STRIDE + $urandom_range(0, CODE_STRIDE - 1), $urandom);
    end

    // A full-table search probes these two entries before it reaches the
    // filled part; holding the top code there steers every other key down.
    queue_load(TABLE_DEPTH / 2 - 1, CP_MAX, $urandom);
    queue_load(TABLE_DEPTH / 4 - 1, CP_MAX, $urandom);

    // Directed lookups over a three-entry table.
    queue_config(REG_ENTRY_COUNT, 3);
    queue_config(REG_FONT_SIZE, 12);
    queue_lookup(0, 16'd12);
    queue_lookup(SPACE_CODE, 16'd12);
    queue_lookup(SPACE_CODE, 16'd13);
    queue_lookup(plan_code[2] + 1, 16'd12);
    queue_lookup(plan_code[3], 16'd12);

    // A count beyond the table depth searches the whole table.
    queue_config(REG_ENTRY_COUNT, 16383);
    queue_config(REG_FONT_SIZE, 16'hFFFF);
    queue_lookup(CP_MAX, 16'hFFFF);
    queue_lookup(0, 16'hFFFF);
    queue_lookup(CP_MAX, 16'h0);
    queue_lookup(plan_code[TABLE_DEPTH / 2 - 1], 16'hFFFF);
    queue_pause();
    queue_config(REG_ENTRY_COUNT, TABLE_DEPTH);
    queue_config(REG_FONT_SIZE, 0);
    queue_lookup(plan_code[FILL_COUNT / 2], 16'h0);
    queue_lookup(plan_code[FILL_COUNT / 2 + 200] + 1, 16'h0);

    // Zero and one entries.
    queue_config(REG_ENTRY_COUNT, 0);
    queue_lookup(0, 16'h0);
    queue_config(REG_ENTRY_COUNT, 1);
    queue_lookup(0, 16'h0);
    queue_lookup(SPACE_CODE, 16'h0);

    // An out-of-order first entry hides itself from the search.
    queue_config(REG_ENTRY_COUNT, 3);
    queue_load(0, plan_code[2] + 100, 32'h1234_5678);
    queue_lookup(plan_code[0], 16'h0);
    queue_load(0, 0, 32'hFFFF_FFFF);
    queue_lookup(0, 16'h0);

    // Random phases, each with its own count and font size.
    while (beats_total < ITEM_COUNT) begin
      roll = $urandom_range(0, 99);
      if (roll < 60) queue_config(REG_ENTRY_COUNT, $urandom_range(1, 64));
      else if (roll < 75) queue_config(REG_ENTRY_COUNT, $urandom_range(65, FILL_COUNT));
      else if (roll < 85) queue_config(REG_ENTRY_COUNT, TABLE_DEPTH);
      else if (roll < 92) queue_config(REG_ENTRY_COUNT, 0);
      else queue_config(REG_ENTRY_COUNT, $urandom_range(TABLE_DEPTH + 1, 16383));
      roll = $urandom_range(0, 99);
      if (roll < 50) queue_config(REG_FONT_SIZE, $urandom_range(0, 65535));
      else if (roll < 75) queue_config(REG_FONT_SIZE, 0);
      else queue_config(REG_FONT_SIZE, 65535);

      // Lookups and loads are aimed at the filled part of the table.
      span = (gen_count > FILL_COUNT) ? FILL_COUNT : gen_count;

      repeat ($urandom_range(20, 100)) begin
        roll = $urandom_range(0, 99);
        if (roll < 2) queue_pause();
        if (roll < 25) begin
          // Loads mostly keep the order; a few break it. The top filled
          // entry keeps its code so searches stay inside the filled part.
          if (span > 0 && $urandom_range(0, 9) < 7) j = $urandom_range(0, span - 1);
          else j = $urandom_range(0, FILL_COUNT - 2);
          if (j > FILL_COUNT - 2) j = FILL_COUNT - 2;
          if ($urandom_range(0, 24) == 0) begin
            code = $urandom_range(0, CP_MAX);
          end else begin
            lo_b = (j == 0) ? 0 : plan_code[j - 1] + 1;
            hi_b = plan_code[j + 1] - 1;
            code = (lo_b <= hi_b) ? $urandom_range(lo_b, hi_b) : plan_code[j];
          end
          queue_load(j, code, $urandom);
        end else begin
          // Lookups mostly hit a searched entry; the rest miss narrowly or widely.
          roll = $urandom_range(0, 99);
          if (span == 0 || roll < 15) begin
            code = $urandom_range(0, CP_MAX);
          end else if (roll < 25) begin
            code = SPACE_CODE;
          end else if (roll < 40) begin
            code = plan_code[$urandom_range(0, span - 1)];
            code = $urandom_range(0, 1) ? code + 1 : code - 1;
            if (code < 0) code = 0;
            if (code > CP_MAX) code = CP_MAX;
          end else begin
            code = plan_code[$urandom_range(0, span - 1)];
          end
          roll = $urandom_range(0, 99);
          if (roll < 80) sz = gen_font;
          else if (roll < 90) sz = gen_font ^ (16'h1 << $urandom_range(0, 15));
          else sz = SIZE_W'($urandom);
          queue_lookup(code, sz);
        end
      end
    end

    while (rst || start || req_backlog.size() != 0 || owed_answers.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (faults == 0) begin
      $display("glyph_index_binary_search regression: pass");
    end else begin
      $display("glyph_index_binary_search regression: fail");
    end
    $finish;
  end

  // Driver: presents beats and register writes from the backlog.
  always @(posedge clk) begin : drive_proc
    logic fire;
    logic nxt_start;
    logic nxt_we;
    if (rst) begin
      start <= 1'b0;
      cfg_we <= 1'b0;
      gap_left = 0;
      quiet_cycles = 0;
      beats_taken = 0;
      shadow_count = '0;
      shadow_font = '0;
    end else begin
      fire = start && !busy;
      nxt_start = start && !fire;
      nxt_we = 1'b0;

      // A register write lands at this edge.
      if (cfg_we) begin
        if (cfg_index == REG_ENTRY_COUNT) shadow_count = cfg_data[COUNT_W-1:0];
        else shadow_font = cfg_data[SIZE_W-1:0];
      end

      // A beat is taken at this edge; sometimes idle for a burst afterwards.
      if (fire) begin
        shadow_beat(cur_req);
        beats_taken++;
        if (beats_taken < beats_total - CALM_TAIL && $urandom_range(0, 3) == 0)
          gap_left = $urandom_range(1, 6);
      end

      // Count cycles in which the block has nothing in flight.
      if (fire || busy || owed_answers.size() != 0) quiet_cycles = 0;
      else if (quiet_cycles < SETTLE_CYCLES) quiet_cycles++;

      if (!nxt_start && req_backlog.size() != 0) begin
        if (req_backlog[0].kind == REQ_BEAT) begin
          if (gap_left > 0) begin
            gap_left--;
          end else begin
            cur_req = req_backlog.pop_front();
            action <= cur_req.act;
            entry_index <= cur_req.idx;
            code_point <= cur_req.code;
            record_offset <= cur_req.offset;
            requested_size <= cur_req.req_size;
            nxt_start = 1'b1;
          end
        end else if (quiet_cycles >= SETTLE_CYCLES) begin
          // Register writes and pauses wait until the block is fully idle.
          if (req_backlog[0].kind == REQ_CFG) begin
            cfg_index <= req_backlog[0].reg_ix;
            cfg_data <= req_backlog[0].reg_val;
            nxt_we = 1'b1;
          end
          void'(req_backlog.pop_front());
        end
      end

      start <= nxt_start;
      cfg_we <= nxt_we;
    end
  end

  // Monitor: each done beat is checked against the oldest owed answer.
  always @(posedge clk) begin : check_proc
    glyph_ans_t want;
    if (!rst && done) begin
      if (owed_answers.size() == 0) begin
        $display("%0t: unexpected result: status %0b offset %h bitmap %0b",
                 $time, status, found_offset, has_bitmap);
        faults++;
      end else begin
        want = owed_answers.pop_front();
        if (status !== want.status) begin
          $display("%0t: status mismatch: expected %0b actual %0b",
                   $time, want.status, status);
          faults++;
        end
        if (found_offset !== want.offset) begin
          $display("%0t: found_offset mismatch: expected %h actual %h",
                   $time, want.offset, found_offset);
          faults++;
        end
        if (has_bitmap !== want.bitmap) begin
          $display("%0t: has_bitmap mismatch: expected %0b actual %0b",
                   $time, want.bitmap, has_bitmap);
          faults++;
        end
      end
    end
  end

  // Watchdog: ends the run when nothing moves for too long.
  always @(posedge clk) begin
    if (rst || (start && !busy) || done || cfg_we) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("glyph_index_binary_search regression: fail");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

endmodule
